/* src/olist_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the ordered record list.
// Used by olist_ctrl, the top level and the checker.
package olist_pkg;

  // List geometry
  localparam int ListDepth = 16;
  localparam int AddrW     = $clog2(ListDepth);
  localparam int PosW      = 5;
  localparam int CntW      = 5;

  // Record fields
  localparam int CodeW   = 16;
  localparam int TagW    = 16;
  localparam int WeightW = 8;
  localparam int RecW    = CodeW + TagW + WeightW;

  typedef enum logic [1:0] {
    KindIns  = 2'd0,
    KindDel  = 2'd1,
    KindFind = 2'd2,
    KindRsvd = 2'd3
  } olist_kind_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StFull     = 2'd1,
    StBadPos   = 2'd2,
    StNotFound = 2'd3
  } olist_status_e;

  typedef enum logic [3:0] {
    SIdle,
    SInsRd,
    SInsWr,
    SInsPut,
    SDelGet,
    SDelRd,
    SDelWr,
    SFindCmp,
    SDone
  } olist_state_e;

  typedef struct packed {
    logic [WeightW-1:0] weight;
    logic [TagW-1:0]    tag;
    logic [CodeW-1:0]   code;
  } olist_rec_t;

  typedef struct packed {
    olist_kind_e     kind;
    logic [PosW-1:0] pos;
    olist_rec_t      rec;
  } olist_req_t;

  typedef struct packed {
    olist_status_e   status;
    logic [PosW-1:0] pos;
    olist_rec_t      rec;
    logic [CntW-1:0] count;
  } olist_res_t;

  // Record store write port
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] addr;
    olist_rec_t       data;
  } olist_wr_t;

endpackage

/* src/ordered_list_insert_delete_find.sv */
`timescale 1ns / 1ps
// Ordered record list top level: stream ports, record RAM, sequencer, output
// register. Uses olist_pkg, olist_ram and olist_ctrl.
//
// Holds up to 16 records in positions 1..count and runs one operation per
// input transfer: insert at a position, delete at a position, or find the
// first record with a given name tag; each transfer returns exactly one result.
// Records live in a single RAM with one write and one registered read port, and
// the sequencer moves one record per read/write pair through it: insert shifts
// the records from the position up by one slot, delete shifts those above it
// down by one, and find scans from position 1 until a tag matches or the list
// ends; a rejected request goes straight to its result.
// The input is not ready while an item is in work; the output register lets the
// next input transfer start while the previous result waits.
module ordered_list_insert_delete_find (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [4:0] position, [20:5] entry_code, [36:21] entry_name_tag,
  // [44:37] entry_weight, rest zero
  input  logic [47:0] s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [4:0] found_position, [20:5] out_code, [36:21] out_name_tag,
  // [44:37] out_weight, [49:45] list_count, rest zero
  output logic [55:0] m_axis_tdata,
  // [1:0] status
  output logic [1:0]  m_axis_tuser
);

  olist_pkg::olist_req_t             req;
  olist_pkg::olist_res_t             res, out_q;
  olist_pkg::olist_wr_t              ram_wr;
  olist_pkg::olist_rec_t             ram_rdata;
  logic [olist_pkg::AddrW-1:0]       ram_raddr;
  logic [olist_pkg::RecW-1:0]        ram_rdata_raw;
  logic                              res_valid, res_ready;
  logic                              out_valid_q;

  // Unpack the input transfer
  assign req.kind       = olist_pkg::olist_kind_e'(s_axis_tuser);
  assign req.pos        = s_axis_tdata[4:0];
  assign req.rec.code   = s_axis_tdata[20:5];
  assign req.rec.tag    = s_axis_tdata[36:21];
  assign req.rec.weight = s_axis_tdata[44:37];

  olist_ram #(
    .Width (olist_pkg::RecW),
    .Depth (olist_pkg::ListDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_wr.we),
    .waddr_i (ram_wr.addr),
    .wdata_i (ram_wr.data),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = olist_pkg::olist_rec_t'(ram_rdata_raw);

  olist_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_wr_o    (ram_wr),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // Output register: load when empty or being drained
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  // Pack the output transfer
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {6'd0, out_q.count, out_q.rec.weight, out_q.rec.tag,
                          out_q.rec.code, out_q.pos};

endmodule

/* src/olist_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module olist_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/olist_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer for the ordered record list: steps one record per pass through the
// single RAM port pair. Uses olist_pkg.
module olist_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  output logic                          req_ready_o,
  input  olist_pkg::olist_req_t         req_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output olist_pkg::olist_res_t         res_o,
  output olist_pkg::olist_wr_t          ram_wr_o,
  output logic [olist_pkg::AddrW-1:0]   ram_raddr_o,
  input  olist_pkg::olist_rec_t         ram_rdata_i
);

  olist_pkg::olist_state_e        state_q, state_d;
  olist_pkg::olist_req_t          req_q, req_d;
  olist_pkg::olist_res_t          res_q, res_d;
  logic [olist_pkg::CntW-1:0]     count_q, count_d;
  logic [olist_pkg::CntW-1:0]     idx_q, idx_d;

  logic [olist_pkg::CntW-1:0]     idx_m1, idx_p1, count_p1, count_m1;
  logic [olist_pkg::PosW-1:0]     in_pos_m1, q_pos_m1;
  logic                           del_fin;

  assign idx_m1    = idx_q - olist_pkg::CntW'(1);
  assign idx_p1    = idx_q + olist_pkg::CntW'(1);
  assign count_p1  = count_q + olist_pkg::CntW'(1);
  assign count_m1  = count_q - olist_pkg::CntW'(1);
  assign in_pos_m1 = req_i.pos - olist_pkg::PosW'(1);
  assign q_pos_m1  = req_q.pos - olist_pkg::PosW'(1);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= olist_pkg::SIdle;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Operation and result payload
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    res_q <= res_d;
    idx_q <= idx_d;
  end

  // Next state, RAM access and result
  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    res_d        = res_q;
    count_d      = count_q;
    idx_d        = idx_q;
    req_ready_o  = 1'b0;
    res_valid_o  = 1'b0;
    ram_wr_o.we   = 1'b0;
    ram_wr_o.addr = idx_q[olist_pkg::AddrW-1:0];
    ram_wr_o.data = ram_rdata_i;
    ram_raddr_o   = idx_q[olist_pkg::AddrW-1:0];
    del_fin       = 1'b0;

    unique case (state_q)
      olist_pkg::SIdle: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          req_d        = req_i;
          res_d        = '0;
          res_d.count  = count_q;
          res_d.status = olist_pkg::StBadPos;
          state_d      = olist_pkg::SDone;
          unique case (req_i.kind)
            olist_pkg::KindIns: begin
              if (count_q == olist_pkg::CntW'(olist_pkg::ListDepth)) begin
                res_d.status = olist_pkg::StFull;
              end else if (req_i.pos == '0 ||
                           {1'b0, req_i.pos} > ({1'b0, count_q} + 6'd1)) begin
                res_d.status = olist_pkg::StBadPos;
              end else if (req_i.pos == count_p1) begin
                state_d = olist_pkg::SInsPut;
              end else begin
                idx_d   = count_q;
                state_d = olist_pkg::SInsRd;
              end
            end
            olist_pkg::KindDel: begin
              if (req_i.pos != '0 && req_i.pos <= count_q) begin
                ram_raddr_o = in_pos_m1[olist_pkg::AddrW-1:0];
                state_d     = olist_pkg::SDelGet;
              end
            end
            olist_pkg::KindFind: begin
              if (count_q == '0) begin
                res_d.status = olist_pkg::StNotFound;
              end else begin
                idx_d       = '0;
                ram_raddr_o = '0;
                state_d     = olist_pkg::SFindCmp;
              end
            end
            default: begin
              res_d.status = olist_pkg::StBadPos;
            end
          endcase
        end
      end

      // Fetch the record below the current destination
      olist_pkg::SInsRd: begin
        ram_raddr_o = idx_m1[olist_pkg::AddrW-1:0];
        state_d     = olist_pkg::SInsWr;
      end

      // Move it up one slot
      olist_pkg::SInsWr: begin
        ram_wr_o.we   = 1'b1;
        ram_wr_o.addr = idx_q[olist_pkg::AddrW-1:0];
        idx_d         = idx_m1;
        state_d       = (idx_m1 >= req_q.pos) ? olist_pkg::SInsRd : olist_pkg::SInsPut;
      end

      // Drop the new record into the freed slot
      olist_pkg::SInsPut: begin
        ram_wr_o.we   = 1'b1;
        ram_wr_o.addr = q_pos_m1[olist_pkg::AddrW-1:0];
        ram_wr_o.data = req_q.rec;
        count_d       = count_p1;
        res_d.status  = olist_pkg::StOk;
        res_d.pos     = req_q.pos;
        res_d.count   = count_p1;
        state_d       = olist_pkg::SDone;
      end

      // Capture the record being removed
      olist_pkg::SDelGet: begin
        res_d.rec = ram_rdata_i;
        idx_d     = req_q.pos;
        if (req_q.pos < count_q) begin
          state_d = olist_pkg::SDelRd;
        end else begin
          del_fin = 1'b1;
        end
      end

      olist_pkg::SDelRd: begin
        ram_raddr_o = idx_q[olist_pkg::AddrW-1:0];
        state_d     = olist_pkg::SDelWr;
      end

      // Move the record down one slot
      olist_pkg::SDelWr: begin
        ram_wr_o.we   = 1'b1;
        ram_wr_o.addr = idx_m1[olist_pkg::AddrW-1:0];
        idx_d         = idx_p1;
        if (idx_p1 < count_q) begin
          state_d = olist_pkg::SDelRd;
        end else begin
          del_fin = 1'b1;
        end
      end

      // Compare one record per cycle, reading the next one ahead
      olist_pkg::SFindCmp: begin
        if (ram_rdata_i.tag == req_q.rec.tag) begin
          res_d.status = olist_pkg::StOk;
          res_d.pos    = idx_p1;
          res_d.rec    = ram_rdata_i;
          state_d      = olist_pkg::SDone;
        end else if (idx_p1 < count_q) begin
          idx_d       = idx_p1;
          ram_raddr_o = idx_p1[olist_pkg::AddrW-1:0];
        end else begin
          res_d.status = olist_pkg::StNotFound;
          state_d      = olist_pkg::SDone;
        end
      end

      // Hold the result until the output stage takes it
      olist_pkg::SDone: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = olist_pkg::SIdle;
        end
      end

      default: begin
        state_d = olist_pkg::SIdle;
      end
    endcase

    // Close out a delete
    if (del_fin) begin
      count_d      = count_m1;
      res_d.status = olist_pkg::StOk;
      res_d.pos    = req_q.pos;
      res_d.count  = count_m1;
      state_d      = olist_pkg::SDone;
    end
  end

  assign res_o = res_q;

endmodule

/* src/olist_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the ordered record list, bound to the top level.
// Uses olist_pkg.
module olist_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [47:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // One item in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after a transfer");

  // Failed operations report position and record as zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != olist_pkg::StOk |-> m_axis_tdata[44:0] == '0)
    else $error("failed result carries data");

  // Full status is only reported on a full list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == olist_pkg::StFull
      |-> m_axis_tdata[49:45] == olist_pkg::CntW'(olist_pkg::ListDepth))
    else $error("full status with room left");

  // Success always names a position between 1 and the list depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == olist_pkg::StOk
      |-> m_axis_tdata[4:0] != '0 && m_axis_tdata[4:0] <= olist_pkg::PosW'(olist_pkg::ListDepth))
    else $error("ok result without a valid position");

endmodule

bind ordered_list_insert_delete_find olist_checker u_olist_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
